// ===== design/static_ip_forward_lookup_top_assert.svh =====
// Assertion macros for the static IP forward lookup checker.
`ifndef STATIC_IP_FORWARD_LOOKUP_TOP_ASSERT_SVH
`define STATIC_IP_FORWARD_LOOKUP_TOP_ASSERT_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define SIFL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sifl assertion failed");

// Same, on the block's own clock and reset names.
`define SIFL_ASSERT_DEF(lbl, prop) `SIFL_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ===== design/sifl_pkg.sv =====
// Types and constants of the static IP forward lookup.
`default_nettype none

package sifl_pkg;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned MAC_W     = 48;
  localparam int unsigned IP_W      = 32;
  localparam int unsigned ETYPE_W   = 16;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned HIT_W     = 5;
  localparam int unsigned PFX_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ETYPE_W-1:0] IPV4_TYPE = 16'h0800;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_PORT0   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT1_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT1_B = 2'd2;

  localparam logic [PFX_W-1:0] PORT0_PFX_RST   = 24'hC0A800;
  localparam logic [PFX_W-1:0] PORT1_A_PFX_RST = 24'hC0A801;
  localparam logic [PFX_W-1:0] PORT1_B_PFX_RST = 24'hC0A802;

  typedef enum logic [MODE_W-1:0] {
    OP_LOAD_LOCAL = 2'd0,
    OP_LOAD_ROUTE = 2'd1,
    OP_LOAD_ARP   = 2'd2,
    OP_FORWARD    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_LOCAL = 3'd2,
    ST_NOT_IPV4  = 3'd3,
    ST_NO_ROUTE  = 3'd4,
    ST_NO_ARP    = 3'd5,
    ST_NO_PORT   = 3'd6,
    ST_FORWARDED = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOCAL,
    S_ROUTE,
    S_ARP,
    S_RESULT
  } back_state_e;

  // Classified item handed from the front to the back
  typedef struct packed {
    op_e              op;
    logic             is_ipv4;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    logic [IP_W-1:0]  gw;
  } cmd_t;

  // One result beat
  typedef struct packed {
    status_e          status;
    logic [MAC_W-1:0] new_dest_mac;
    logic [MAC_W-1:0] new_src_mac;
    logic             out_port;
    logic [HIT_W-1:0] route_hit_index;
    logic [HIT_W-1:0] arp_hit_index;
  } res_t;

endpackage

`default_nettype wire

// ===== design/sifl_if.sv =====
// Valid/ready channel interfaces for items in and results out.
`default_nettype none

interface sifl_in_if import sifl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [MAC_W-1:0]     hw_addr;
  logic [IP_W-1:0]      ip_addr;
  logic [IP_W-1:0]      gateway_ip;
  logic [ETYPE_W-1:0]   ether_type;

  modport source (output valid, mode, hw_addr, ip_addr, gateway_ip, ether_type,
                  input ready);
  modport sink (input valid, mode, hw_addr, ip_addr, gateway_ip, ether_type,
                output ready);
endinterface

interface sifl_out_if import sifl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [MAC_W-1:0]     new_dest_mac;
  logic [MAC_W-1:0]     new_src_mac;
  logic                 out_port;
  logic [HIT_W-1:0]     route_hit_index;
  logic [HIT_W-1:0]     arp_hit_index;

  modport source (output valid, status, new_dest_mac, new_src_mac, out_port,
                  route_hit_index, arp_hit_index, input ready);
  modport sink (input valid, status, new_dest_mac, new_src_mac, out_port,
                route_hit_index, arp_hit_index, output ready);
endinterface

`default_nettype wire

// ===== design/sifl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sifl_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/sifl_front.sv =====
// Front end: accepts input beats, decodes the mode and pre-checks the ethertype.
`default_nettype none

module sifl_front import sifl_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sifl_in_if.sink    in_i,
  output      logic  cmd_valid_o,
  input  wire logic  cmd_ready_i,
  output      cmd_t  cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;

  // Stage is free when empty or when its beat moves on this cycle
  assign in_i.ready = !valid_q || cmd_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // Classify the incoming beat
  always_comb begin
    cmd_d.op      = op_e'(in_i.mode);
    cmd_d.is_ipv4 = (in_i.ether_type == IPV4_TYPE);
    cmd_d.mac     = in_i.hw_addr;
    cmd_d.ip      = in_i.ip_addr;
    cmd_d.gw      = in_i.gateway_ip;
  end

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

// ===== design/sifl_fifo.sv =====
// Two-entry queue of classified items between front and back.
`default_nettype none

module sifl_fifo import sifl_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output      logic  push_ready_o,
  input  wire cmd_t  push_data_i,
  output      logic  pop_valid_o,
  input  wire logic  pop_ready_i,
  output      cmd_t  pop_data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);

  cmd_t            mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != (PW+1)'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  // Pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = wptr_q + PW'(1);
    end
    if (pop) begin
      rptr_d = rptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + (PW+1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/sifl_back.sv =====
// Back end: owns the three tables, runs loads and the forward lookup sequence.
`default_nettype none

module sifl_back import sifl_pkg::*; #(
  parameter int unsigned LOCAL_ENTRIES = 32,
  parameter int unsigned ROUTE_ENTRIES = 32,
  parameter int unsigned ARP_ENTRIES   = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [PFX_W-1:0]      cfg_wdata_i,
  input  wire logic                  cmd_valid_i,
  output      logic                  cmd_ready_o,
  input  wire cmd_t                  cmd_i,
  sifl_out_if.source                 out_o
);

  // Address and count widths per table
  localparam int unsigned LAW   = (LOCAL_ENTRIES > 1) ? $clog2(LOCAL_ENTRIES) : 1;
  localparam int unsigned RAW   = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int unsigned AAW   = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
  localparam int unsigned LCW   = $clog2(LOCAL_ENTRIES + 1);
  localparam int unsigned RCW   = $clog2(ROUTE_ENTRIES + 1);
  localparam int unsigned ACW   = $clog2(ARP_ENTRIES + 1);
  localparam int unsigned SW_LR = (LCW > RCW) ? LCW : RCW;
  localparam int unsigned SW    = (SW_LR > ACW) ? SW_LR : ACW;
  localparam int unsigned RW    = 2 * IP_W;
  localparam int unsigned AW    = IP_W + MAC_W;

  back_state_e state_q, state_d;

  cmd_t             cmd_q, cmd_d;
  logic [LCW-1:0]   lcnt_q, lcnt_d;
  logic [RCW-1:0]   rcnt_q, rcnt_d;
  logic [ACW-1:0]   acnt_q, acnt_d;
  logic [SW-1:0]    idx_q, idx_d, chk_q, chk_d;
  logic             chk_v_q, chk_v_d;
  logic [IP_W-1:0]  gw_q, gw_d;
  logic [HIT_W-1:0] rhit_q, rhit_d;
  res_t             res_q, res_d;
  res_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic [PFX_W-1:0] port0_q, port1_a_q, port1_b_q;

  logic             lram_we, rram_we, aram_we;
  logic [MAC_W-1:0] lram_rdata;
  logic [RW-1:0]    rram_rdata;
  logic [AW-1:0]    aram_rdata;

  logic             pop, slot_free;
  logic             lfull, rfull, afull;
  logic             local_hit, route_hit, arp_hit;
  logic             local_last, route_last, arp_last;
  logic [PFX_W-1:0] pfx;
  logic             port0_m, port1_m;

  // Table storage
  sifl_ram #(.WIDTH(MAC_W), .DEPTH(LOCAL_ENTRIES)) u_local_ram (
    .clk_i   (clk_i),
    .we_i    (lram_we),
    .waddr_i (lcnt_q[LAW-1:0]),
    .wdata_i (cmd_i.mac),
    .raddr_i (idx_q[LAW-1:0]),
    .rdata_o (lram_rdata)
  );

  sifl_ram #(.WIDTH(RW), .DEPTH(ROUTE_ENTRIES)) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (rram_we),
    .waddr_i (rcnt_q[RAW-1:0]),
    .wdata_i ({cmd_i.ip, cmd_i.gw}),
    .raddr_i (idx_q[RAW-1:0]),
    .rdata_o (rram_rdata)
  );

  sifl_ram #(.WIDTH(AW), .DEPTH(ARP_ENTRIES)) u_arp_ram (
    .clk_i   (clk_i),
    .we_i    (aram_we),
    .waddr_i (acnt_q[AAW-1:0]),
    .wdata_i ({cmd_i.ip, cmd_i.mac}),
    .raddr_i (idx_q[AAW-1:0]),
    .rdata_o (aram_rdata)
  );

  // Compares on the entry read last cycle; chk_q is its index
  assign lfull      = (lcnt_q == LCW'(LOCAL_ENTRIES));
  assign rfull      = (rcnt_q == RCW'(ROUTE_ENTRIES));
  assign afull      = (acnt_q == ACW'(ARP_ENTRIES));
  assign local_hit  = chk_v_q && (lram_rdata == cmd_q.mac);
  assign route_hit  = chk_v_q && (rram_rdata[RW-1:IP_W] == cmd_q.ip);
  assign arp_hit    = chk_v_q && (aram_rdata[AW-1:MAC_W] == gw_q);
  assign local_last = chk_v_q && ((chk_q + SW'(1)) == SW'(lcnt_q));
  assign route_last = chk_v_q && ((chk_q + SW'(1)) == SW'(rcnt_q));
  assign arp_last   = chk_v_q && ((chk_q + SW'(1)) == SW'(acnt_q));

  // Egress port by the upper 24 address bits
  assign pfx     = cmd_q.ip[IP_W-1:IP_W-PFX_W];
  assign port0_m = (pfx == port0_q);
  assign port1_m = (pfx == port1_a_q) || (pfx == port1_b_q);

  assign slot_free = !out_valid_q || out_o.ready;
  assign pop       = cmd_valid_i && cmd_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_FORWARD && lcnt_q != '0) begin
            state_d = S_LOCAL;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_LOCAL: begin
        if (local_hit) begin
          if (cmd_q.is_ipv4 && rcnt_q != '0) begin
            state_d = S_ROUTE;
          end else begin
            state_d = S_RESULT;
          end
        end else if (local_last) begin
          state_d = S_RESULT;
        end
      end
      S_ROUTE: begin
        if (route_hit) begin
          if (acnt_q != '0) begin
            state_d = S_ARP;
          end else begin
            state_d = S_RESULT;
          end
        end else if (route_last) begin
          state_d = S_RESULT;
        end
      end
      S_ARP: begin
        if (arp_hit || arp_last) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cmd_ready_o = 1'b0;
    cmd_d       = cmd_q;
    lcnt_d      = lcnt_q;
    rcnt_d      = rcnt_q;
    acnt_d      = acnt_q;
    idx_d       = idx_q;
    chk_d       = chk_q;
    chk_v_d     = chk_v_q;
    gw_d        = gw_q;
    rhit_d      = rhit_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    lram_we     = 1'b0;
    rram_we     = 1'b0;
    aram_we     = 1'b0;

    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (pop) begin
          cmd_d        = cmd_i;
          res_d        = '0;
          res_d.status = ST_LOADED;
          idx_d        = '0;
          chk_v_d      = 1'b0;
          case (cmd_i.op)
            OP_LOAD_LOCAL: begin
              if (lfull) begin
                res_d.status = ST_FULL;
              end else begin
                lram_we = 1'b1;
                lcnt_d  = lcnt_q + LCW'(1);
              end
            end
            OP_LOAD_ROUTE: begin
              if (rfull) begin
                res_d.status = ST_FULL;
              end else begin
                rram_we = 1'b1;
                rcnt_d  = rcnt_q + RCW'(1);
              end
            end
            OP_LOAD_ARP: begin
              if (afull) begin
                res_d.status = ST_FULL;
              end else begin
                aram_we = 1'b1;
                acnt_d  = acnt_q + ACW'(1);
              end
            end
            OP_FORWARD: begin
              res_d.status = ST_NOT_LOCAL;
            end
            default: res_d.status = ST_LOADED;
          endcase
        end
      end

      S_LOCAL: begin
        idx_d   = idx_q + SW'(1);
        chk_d   = idx_q;
        chk_v_d = 1'b1;
        if (local_hit) begin
          idx_d   = '0;
          chk_v_d = 1'b0;
          if (!cmd_q.is_ipv4) begin
            res_d.status = ST_NOT_IPV4;
          end else begin
            res_d.status = ST_NO_ROUTE;
          end
        end
      end

      S_ROUTE: begin
        idx_d   = idx_q + SW'(1);
        chk_d   = idx_q;
        chk_v_d = 1'b1;
        if (route_hit) begin
          idx_d                 = '0;
          chk_v_d               = 1'b0;
          gw_d                  = rram_rdata[IP_W-1:0];
          rhit_d                = HIT_W'(chk_q);
          res_d.status          = ST_NO_ARP;
          res_d.route_hit_index = HIT_W'(chk_q);
        end
      end

      S_ARP: begin
        idx_d   = idx_q + SW'(1);
        chk_d   = idx_q;
        chk_v_d = 1'b1;
        if (arp_hit) begin
          res_d.route_hit_index = rhit_q;
          res_d.arp_hit_index   = HIT_W'(chk_q);
          if (port0_m || port1_m) begin
            res_d.status       = ST_FORWARDED;
            res_d.new_dest_mac = aram_rdata[MAC_W-1:0];
            res_d.new_src_mac  = cmd_q.mac;
            res_d.out_port     = !port0_m;
          end else begin
            res_d.status = ST_NO_PORT;
          end
        end
      end

      S_RESULT: begin
        if (slot_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lcnt_q      <= '0;
      rcnt_q      <= '0;
      acnt_q      <= '0;
      idx_q       <= '0;
      chk_q       <= '0;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lcnt_q      <= lcnt_d;
      rcnt_q      <= rcnt_d;
      acnt_q      <= acnt_d;
      idx_q       <= idx_d;
      chk_q       <= chk_d;
      chk_v_q     <= chk_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    gw_q   <= gw_d;
    rhit_q <= rhit_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // Port prefix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port0_q   <= PORT0_PFX_RST;
      port1_a_q <= PORT1_A_PFX_RST;
      port1_b_q <= PORT1_B_PFX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PORT0:   port0_q   <= cfg_wdata_i;
        CFG_PORT1_A: port1_a_q <= cfg_wdata_i;
        CFG_PORT1_B: port1_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_q.status;
  assign out_o.new_dest_mac    = out_q.new_dest_mac;
  assign out_o.new_src_mac     = out_q.new_src_mac;
  assign out_o.out_port        = out_q.out_port;
  assign out_o.route_hit_index = out_q.route_hit_index;
  assign out_o.arp_hit_index   = out_q.arp_hit_index;

endmodule

`default_nettype wire

// ===== design/static_ip_forward_lookup_top.sv =====
// Top level of the static IP forward lookup.
// Keeps a local MAC table, a route table and an ARP table, each filled in order
// by load beats, and looks up forward beats against them: local MAC, ethertype
// 0x0800, exact route (lowest index), ARP hit on the gateway (lowest index),
// then the /24 egress port prefix. Each table sits in a RAM with one read port
// that is scanned one entry per cycle: a load writes its table without a scan,
// and a forward beat scans each table that it searches up to the hit, or up to
// the table's fill count on a miss. A one-beat front register and a two-entry
// queue keep taking input while the back end searches; a result waits in the
// output register until taken. The tables need no clearing after reset: only
// entries below each fill count are searched. The user is to write port
// prefixes only while the block is idle; the block itself does not enforce it.
`default_nettype none

module static_ip_forward_lookup_top import sifl_pkg::*; #(
  parameter int unsigned LOCAL_ENTRIES = 32,
  parameter int unsigned ROUTE_ENTRIES = 32,
  parameter int unsigned ARP_ENTRIES   = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  sifl_in_if.sink                    in_i,
  sifl_out_if.source                 out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [PFX_W-1:0]      cfg_wdata_i
);

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  sifl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  sifl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  sifl_back #(
    .LOCAL_ENTRIES (LOCAL_ENTRIES),
    .ROUTE_ENTRIES (ROUTE_ENTRIES),
    .ARP_ENTRIES   (ARP_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== design/sifl_checker.sv =====
// Port-level checker for the static IP forward lookup, bound to the top level.
`default_nettype none

`include "static_ip_forward_lookup_top_assert.svh"

module sifl_checker import sifl_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_i,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic [STATUS_W-1:0]  out_status_i,
  input wire logic [MAC_W-1:0]     out_dest_mac_i,
  input wire logic [MAC_W-1:0]     out_src_mac_i,
  input wire logic                 out_port_i,
  input wire logic [HIT_W-1:0]     out_rhit_i,
  input wire logic [HIT_W-1:0]     out_ahit_i
);

  logic [2:0] pend_q, pend_d;
  logic       in_acc, out_acc;
  logic       early_status;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Statuses decided before a route hit carry no hit indexes
  assign early_status = (out_status_i == ST_LOADED) || (out_status_i == ST_FULL) ||
                        (out_status_i == ST_NOT_LOCAL) || (out_status_i == ST_NOT_IPV4) ||
                        (out_status_i == ST_NO_ROUTE);

  // Beats accepted but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `SIFL_ASSERT_DEF(a_no_extra_result, out_acc |-> pend_q != 3'd0)
  `SIFL_ASSERT_DEF(a_zero_unless_fwd, out_valid_i && out_status_i != ST_FORWARDED |-> out_dest_mac_i == '0 && out_src_mac_i == '0 && !out_port_i)
  `SIFL_ASSERT_DEF(a_early_no_index, out_valid_i && early_status |-> out_rhit_i == '0 && out_ahit_i == '0)
  `SIFL_ASSERT_DEF(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))

endmodule

bind static_ip_forward_lookup_top sifl_checker u_sifl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_status_i   (out_o.status),
  .out_dest_mac_i (out_o.new_dest_mac),
  .out_src_mac_i  (out_o.new_src_mac),
  .out_port_i     (out_o.out_port),
  .out_rhit_i     (out_o.route_hit_index),
  .out_ahit_i     (out_o.arp_hit_index)
);

`default_nettype wire

// ===== dv/tb_static_ip_forward_lookup_top.sv =====
// Self-checking testbench for the static IP forward lookup: table loads, frame lookups, prefixes.
`timescale 1ns / 100ps

module tb_static_ip_forward_lookup_top;
  import sifl_pkg::*;

  localparam int unsigned LOCAL_DEPTH = 32;
  localparam int unsigned ROUTE_DEPTH = 32;
  localparam int unsigned ARP_DEPTH   = 32;
  localparam int          CLK_PERIOD  = 8;
  localparam int          RAND_PHASES = 6;
  localparam int          PHASE_BEATS = 315;
  localparam int          GW_POOL     = 24;
  localparam int          HOLD_AFTER  = 400;
  localparam int          HOLD_CYCLES = 500;
  localparam int          END_DRAIN   = 120;
  localparam int          STALL_LIMIT = 4000;
  // index past the last prefix register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    op_e                mode;
    logic [MAC_W-1:0]   mac;
    logic [IP_W-1:0]    ip;
    logic [IP_W-1:0]    gw;
    logic [ETYPE_W-1:0] etype;
  } lookup_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [PFX_W-1:0]     cfg_wdata_i;

  sifl_in_if  in_if ();
  sifl_out_if out_if ();

  static_ip_forward_lookup_top #(
    .LOCAL_ENTRIES(LOCAL_DEPTH),
    .ROUTE_ENTRIES(ROUTE_DEPTH),
    .ARP_ENTRIES  (ARP_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Lookup predictor state: tables, fill counts, port prefixes
  logic [MAC_W-1:0] local_tbl [LOCAL_DEPTH];
  int unsigned      local_fill;
  logic [IP_W-1:0]  route_dst [ROUTE_DEPTH];
  logic [IP_W-1:0]  route_gw  [ROUTE_DEPTH];
  int unsigned      route_fill;
  logic [IP_W-1:0]  arp_ip    [ARP_DEPTH];
  logic [MAC_W-1:0] arp_mac   [ARP_DEPTH];
  int unsigned      arp_fill;
  logic [PFX_W-1:0] port0_pfx, port1a_pfx, port1b_pfx;

  // Stimulus-side view of what has been loaded, used to aim frames at real entries
  logic [MAC_W-1:0] gen_locals[$];
  logic [IP_W-1:0]  gen_route_dsts[$];
  int unsigned      gen_arp_count;
  logic [IP_W-1:0]  gw_pool  [GW_POOL];
  logic [PFX_W-1:0] pfx_pool [8];

  lookup_beat_t pending_beats[$];
  res_t         pending_lookups[$];
  lookup_beat_t drive_beat;
  lookup_beat_t seen_beat;
  res_t         expected;

  int beats_queued    = 0;
  int frames_queued   = 0;
  int results_checked = 0;
  int fail_count      = 0;
  int settings_done   = 0;
  int status_seen [8];

  // sender and receiver pacing
  bit beat_taken     = 1'b0;
  int burst_left     = 1;
  int gap_left       = 0;
  int rx_cycle       = 0;
  int hold_left      = 0;
  bit long_hold_done = 1'b0;
  int idle_cycles    = 0;

  function automatic logic [MAC_W-1:0] rand48();
    return MAC_W'({$urandom, $urandom});
  endfunction

  // Expected result of one accepted beat; updates the tables on loads
  function automatic res_t compute_lookup(lookup_beat_t b);
    res_t r;
    int   rh;
    int   ah;
    bit   hit;
    r   = '0;
    rh  = -1;
    ah  = -1;
    hit = 1'b0;
    case (b.mode)
      OP_LOAD_LOCAL: begin
        if (local_fill >= LOCAL_DEPTH) r.status = ST_FULL;
        else begin
          local_tbl[local_fill] = b.mac;
          local_fill++;
        end
        return r;
      end
      OP_LOAD_ROUTE: begin
        if (route_fill >= ROUTE_DEPTH) r.status = ST_FULL;
        else begin
          route_dst[route_fill] = b.ip;
          route_gw[route_fill]  = b.gw;
          route_fill++;
        end
        return r;
      end
      OP_LOAD_ARP: begin
        if (arp_fill >= ARP_DEPTH) r.status = ST_FULL;
        else begin
          arp_ip[arp_fill]  = b.ip;
          arp_mac[arp_fill] = b.mac;
          arp_fill++;
        end
        return r;
      end
      default: ;
    endcase

    // forward: local MAC, ethertype, route, ARP on the gateway, then port prefix
    for (int i = 0; i < local_fill; i++)
      if (local_tbl[i] == b.mac) hit = 1'b1;
    if (!hit) begin
      r.status = ST_NOT_LOCAL;
      return r;
    end
    if (b.etype != IPV4_TYPE) begin
      r.status = ST_NOT_IPV4;
      return r;
    end
    for (int i = 0; i < route_fill; i++)
      if (rh < 0 && route_dst[i] == b.ip) rh = i;
    if (rh < 0) begin
      r.status = ST_NO_ROUTE;
      return r;
    end
    r.route_hit_index = HIT_W'(rh);
    for (int i = 0; i < arp_fill; i++)
      if (ah < 0 && arp_ip[i] == route_gw[rh]) ah = i;
    if (ah < 0) begin
      r.status = ST_NO_ARP;
      return r;
    end
    r.arp_hit_index = HIT_W'(ah);
    if (b.ip[IP_W-1:8] == port0_pfx) r.out_port = 1'b0;
    else if (b.ip[IP_W-1:8] == port1a_pfx || b.ip[IP_W-1:8] == port1b_pfx) r.out_port = 1'b1;
    else begin
      r.status = ST_NO_PORT;
      return r;
    end
    r.status       = ST_FORWARDED;
    r.new_dest_mac = arp_mac[ah];
    r.new_src_mac  = b.mac;
    return r;
  endfunction

  // Append a beat for the driver and track what the loads put in the tables
  function automatic void queue_beat(op_e mode, logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip,
                                     logic [IP_W-1:0] gw, logic [ETYPE_W-1:0] etype);
    lookup_beat_t b;
    b.mode  = mode;
    b.mac   = mac;
    b.ip    = ip;
    b.gw    = gw;
    b.etype = etype;
    pending_beats.push_back(b);
    beats_queued++;
    case (mode)
      OP_LOAD_LOCAL: if (gen_locals.size() < LOCAL_DEPTH) gen_locals.push_back(mac);
      OP_LOAD_ROUTE: if (gen_route_dsts.size() < ROUTE_DEPTH) gen_route_dsts.push_back(ip);
      OP_LOAD_ARP:   if (gen_arp_count < ARP_DEPTH) gen_arp_count++;
      default:       frames_queued++;
    endcase
  endfunction

  function automatic void check_field(string name, logic [MAC_W-1:0] want,
                                      logic [MAC_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // All four register indexes in one go, only while nothing is in flight
  task automatic program_prefixes(input logic [PFX_W-1:0] p0, p1a, p1b, junk);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PORT0;
    cfg_wdata_i <= p0;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_PORT1_A;
    cfg_wdata_i <= p1a;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_PORT1_B;
    cfg_wdata_i <= p1b;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_UNUSED;
    cfg_wdata_i <= junk;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_done++;
  endtask

  // Input driver: bursts with gaps, holds a beat until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && !(in_if.valid && !beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (pending_beats.size() > 0) begin
        drive_beat = pending_beats.pop_front();
        in_if.valid      <= 1'b1;
        in_if.mode       <= drive_beat.mode;
        in_if.hw_addr    <= drive_beat.mac;
        in_if.ip_addr    <= drive_beat.ip;
        in_if.gateway_ip <= drive_beat.gw;
        in_if.ether_type <= drive_beat.etype;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: rotating stall patterns, with one long hold-off after HOLD_AFTER results
  always @(negedge clk_i) begin
    rx_cycle++;
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (!long_hold_done && results_checked >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left      = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      case ((rx_cycle / 600) % 4)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 1) == 1);
        2:       out_if.ready <= ((rx_cycle % 5) < 3);
        default: out_if.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Monitor: register writes, input beats into the predictor, result beats checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PORT0:   port0_pfx  = cfg_wdata_i;
          CFG_PORT1_A: port1a_pfx = cfg_wdata_i;
          CFG_PORT1_B: port1b_pfx = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        seen_beat.mode  = op_e'(in_if.mode);
        seen_beat.mac   = in_if.hw_addr;
        seen_beat.ip    = in_if.ip_addr;
        seen_beat.gw    = in_if.gateway_ip;
        seen_beat.etype = in_if.ether_type;
        pending_lookups.push_back(compute_lookup(seen_beat));
        beat_taken = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_lookups.size() == 0) begin
          $error("result beat with no lookup outstanding");
          fail_count++;
        end else begin
          expected = pending_lookups.pop_front();
          status_seen[expected.status]++;
          check_field("status", MAC_W'(expected.status), MAC_W'(out_if.status));
          check_field("new_dest_mac", expected.new_dest_mac, out_if.new_dest_mac);
          check_field("new_src_mac", expected.new_src_mac, out_if.new_src_mac);
          check_field("out_port", MAC_W'(expected.out_port), MAC_W'(out_if.out_port));
          check_field("route_hit_index", MAC_W'(expected.route_hit_index),
                      MAC_W'(out_if.route_hit_index));
          check_field("arp_hit_index", MAC_W'(expected.arp_hit_index),
                      MAC_W'(out_if.arp_hit_index));
          results_checked++;
        end
      end
    end
  end

  // Watchdog on cycles without any beat moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [MAC_W-1:0]   mac;
    logic [IP_W-1:0]    ip;
    logic [IP_W-1:0]    gw;
    logic [ETYPE_W-1:0] etype;
    logic [PFX_W-1:0]   p0, p1a, p1b;
    op_e                op;
    int                 roll;
    bit                 tables_full;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_PORT0;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.mode       = OP_LOAD_LOCAL;
    in_if.hw_addr    = '0;
    in_if.ip_addr    = '0;
    in_if.gateway_ip = '0;
    in_if.ether_type = '0;
    out_if.ready     = 1'b0;
    local_fill       = 0;
    route_fill       = 0;
    arp_fill         = 0;
    gen_arp_count    = 0;
    port0_pfx        = PORT0_PFX_RST;
    port1a_pfx       = PORT1_A_PFX_RST;
    port1b_pfx       = PORT1_B_PFX_RST;
    foreach (status_seen[k]) status_seen[k] = 0;
    foreach (gw_pool[k]) gw_pool[k] = $urandom;
    pfx_pool[0] = PORT0_PFX_RST;
    pfx_pool[1] = PORT1_A_PFX_RST;
    pfx_pool[2] = PORT1_B_PFX_RST;
    pfx_pool[3] = '0;
    pfx_pool[4] = '1;
    pfx_pool[5] = 24'h0A0000;
    pfx_pool[6] = PFX_W'($urandom);
    pfx_pool[7] = PFX_W'($urandom);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    program_prefixes(PORT0_PFX_RST, PORT1_A_PFX_RST, PORT1_B_PFX_RST, '1);

    // Directed: empty tables, each failing check, duplicates, all three ports
    queue_beat(OP_FORWARD,    '0, 32'hC0A8_0005, '0, IPV4_TYPE);
    queue_beat(OP_LOAD_LOCAL, '0, '0, '0, '0);
    queue_beat(OP_LOAD_LOCAL, '1, '1, '1, '1);
    queue_beat(OP_FORWARD,    '1, 32'hC0A8_0005, '0, 16'h0801);
    queue_beat(OP_FORWARD,    '0, 32'hC0A8_0005, '0, IPV4_TYPE);
    queue_beat(OP_LOAD_ROUTE, '0, 32'hC0A8_0005, 32'h0A00_0001, '0);
    queue_beat(OP_LOAD_ROUTE, '0, 32'hC0A8_0107, 32'h0A00_0002, '0);
    queue_beat(OP_LOAD_ROUTE, '0, '0, '1, '0);
    queue_beat(OP_LOAD_ROUTE, '0, 32'hC0A8_0005, 32'h0A00_0002, '0);
    queue_beat(OP_FORWARD,    '0, 32'hC0A8_0005, '0, IPV4_TYPE);
    queue_beat(OP_LOAD_ARP,   48'h1234_5678_9ABC, 32'h0A00_0001, '0, '0);
    queue_beat(OP_LOAD_ARP,   '1, 32'h0A00_0002, '0, '0);
    queue_beat(OP_LOAD_ARP,   '0, '1, '0, '0);
    queue_beat(OP_LOAD_ARP,   48'h1, 32'h0A00_0001, '0, '0);
    queue_beat(OP_FORWARD,    '0, 32'hC0A8_0005, '1, IPV4_TYPE);
    queue_beat(OP_FORWARD,    '1, 32'hC0A8_0107, '0, IPV4_TYPE);
    queue_beat(OP_FORWARD,    '0, '0, '0, IPV4_TYPE);
    queue_beat(OP_LOAD_ROUTE, '0, 32'hC0A8_02FF, 32'h0A00_0002, '0);
    queue_beat(OP_FORWARD,    '1, 32'hC0A8_02FF, '0, IPV4_TYPE);
    queue_beat(OP_FORWARD,    '0, '1, '0, '1);
    queue_beat(OP_FORWARD,    '0, 32'hC0A8_0005, '0, '0);
    queue_beat(OP_FORWARD,    rand48(), 32'hC0A8_0005, '0, IPV4_TYPE);

    // Random phases, each under its own prefix setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait (results_checked == beats_queued);
      case (ph)
        0: begin
          p0  = pfx_pool[0];
          p1a = pfx_pool[1];
          p1b = pfx_pool[2];
        end
        1: begin
          p0  = '0;
          p1a = '1;
          p1b = pfx_pool[5];
        end
        2: begin
          p0  = '1;
          p1a = '0;
          p1b = pfx_pool[0];
        end
        3: begin
          // port 0 and port 1 on the same prefix: port 0 must win
          p0  = pfx_pool[$urandom_range(0, 7)];
          p1a = p0;
          p1b = pfx_pool[$urandom_range(0, 7)];
        end
        4: begin
          p0  = pfx_pool[$urandom_range(0, 7)];
          p1a = pfx_pool[$urandom_range(0, 7)];
          p1b = pfx_pool[$urandom_range(0, 7)];
        end
        default: begin
          p0  = PFX_W'($urandom);
          p1a = pfx_pool[$urandom_range(0, 7)];
          p1b = PFX_W'($urandom);
        end
      endcase
      program_prefixes(p0, p1a, p1b, PFX_W'($urandom));

      for (int n = 0; n < PHASE_BEATS; n++) begin
        roll  = $urandom_range(0, 99);
        mac   = rand48();
        ip    = $urandom;
        gw    = $urandom;
        etype = ETYPE_W'($urandom);
        tables_full = gen_locals.size() >= LOCAL_DEPTH &&
                      gen_route_dsts.size() >= ROUTE_DEPTH && gen_arp_count >= ARP_DEPTH;
        if (roll < (tables_full ? 6 : 30)) begin
          // table load; keeps hitting full tables once they are filled
          op = op_e'($urandom_range(0, 2));
          case (op)
            OP_LOAD_LOCAL: begin
              case ($urandom_range(0, 9))
                0: mac = '0;
                1: mac = '1;
                2: if (gen_locals.size() > 0)
                     mac = gen_locals[$urandom_range(0, gen_locals.size() - 1)];
                default: ;
              endcase
            end
            OP_LOAD_ROUTE: begin
              if ($urandom_range(0, 6) == 0 && gen_route_dsts.size() > 0)
                ip = gen_route_dsts[$urandom_range(0, gen_route_dsts.size() - 1)];
              else
                ip = {pfx_pool[$urandom_range(0, 7)], ip[7:0]};
              if ($urandom_range(0, 6) != 0) gw = gw_pool[$urandom_range(0, GW_POOL - 1)];
            end
            default: begin
              if ($urandom_range(0, 9) != 0) ip = gw_pool[$urandom_range(0, GW_POOL - 1)];
              if ($urandom_range(0, 19) == 0) mac = '0;
              else if ($urandom_range(0, 19) == 0) mac = '1;
            end
          endcase
          queue_beat(op, mac, ip, gw, etype);
        end else if (roll < (tables_full ? 14 : 38)) begin
          queue_beat(op_e'($urandom_range(0, 3)), mac, ip, gw, etype);
        end else begin
          // frame aimed at loaded entries, sometimes broken on one check
          if (gen_locals.size() > 0)
            mac = gen_locals[$urandom_range(0, gen_locals.size() - 1)];
          if (gen_route_dsts.size() > 0)
            ip = gen_route_dsts[$urandom_range(0, gen_route_dsts.size() - 1)];
          etype = IPV4_TYPE;
          case ($urandom_range(0, 15))
            0: mac = rand48();
            1: mac = mac ^ (MAC_W'(1) << $urandom_range(0, MAC_W - 1));
            2: etype = ETYPE_W'($urandom);
            3: etype = etype ^ (ETYPE_W'(1) << $urandom_range(0, ETYPE_W - 1));
            4: ip = $urandom;
            5: ip = ip ^ (IP_W'(1) << $urandom_range(0, IP_W - 1));
            default: ;
          endcase
          queue_beat(OP_FORWARD, mac, ip, gw, etype);
        end
      end
    end

    wait (results_checked == beats_queued);
    repeat (END_DRAIN) @(posedge clk_i);

    $display("Covered %0d beats: %0d frame lookups, %0d table loads, %0d prefix settings",
             beats_queued, frames_queued, beats_queued - frames_queued, settings_done);
    $display("Status mix: loaded %0d full %0d not-local %0d not-ipv4 %0d no-route %0d %s%0d %s%0d %s%0d",
             status_seen[ST_LOADED], status_seen[ST_FULL], status_seen[ST_NOT_LOCAL],
             status_seen[ST_NOT_IPV4], status_seen[ST_NO_ROUTE], "no-arp ",
             status_seen[ST_NO_ARP], "no-port ", status_seen[ST_NO_PORT], "forwarded ",
             status_seen[ST_FORWARDED]);
    if (fail_count == 0 && pending_lookups.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sifl_pkg.sv
design/sifl_if.sv
design/sifl_ram.sv
design/sifl_front.sv
design/sifl_fifo.sv
design/sifl_back.sv
design/static_ip_forward_lookup_top.sv
design/sifl_checker.sv
dv/tb_static_ip_forward_lookup_top.sv
